// ----- design/pfta_pkg.sv -----
package pfta_pkg;

    localparam int OP_BITS     = 2;
    localparam int STATUS_BITS = 2;
    localparam int COUNT_BITS  = 11;
    localparam int OUT_FRAME_BITS = 40;
    localparam int REGION_BITS = 40;

    localparam logic [OP_BITS-1:0] OP_ADD   = 2'd0;
    localparam logic [OP_BITS-1:0] OP_ALLOC = 2'd1;
    localparam logic [OP_BITS-1:0] OP_FREE  = 2'd2;
    localparam logic [OP_BITS-1:0] OP_QUERY = 2'd3;

    localparam logic [STATUS_BITS-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_BITS-1:0] ST_NO_RUN    = 2'd1;
    localparam logic [STATUS_BITS-1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [STATUS_BITS-1:0] ST_FULL      = 2'd3;

endpackage

// ----- design/page_frame_table_allocator.sv -----
// Page frame table allocator. The table is a ring of TABLE_DEPTH cells that
// rotates past one processing head, one entry per cycle during a pass, so
// add, free and allocate work in whole rotations: free one, add region a
// clamp step, a fit step, then one, allocate one on a miss and two on a hit
// (search rotation, then marking rotation); query and zero-page allocate none.
// start is taken while busy is low; the result appears for exactly one cycle
// with done high and cannot be held off, so capture it on that cycle.
// used_pages and total_pages are valid while done is high.
module page_frame_table_allocator #(
    parameter int TABLE_DEPTH = 1024,
    parameter int FRAME_BITS  = 40
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic [pfta_pkg::OP_BITS-1:0]         operation,
    input  logic [pfta_pkg::REGION_BITS-1:0]     frame,
    input  logic [pfta_pkg::COUNT_BITS-1:0]      page_count,
    input  logic [pfta_pkg::REGION_BITS-1:0]     region_pages,
    output logic                                 done,
    output logic [pfta_pkg::STATUS_BITS-1:0]     status,
    output logic [pfta_pkg::OUT_FRAME_BITS-1:0]  result_frame,
    output logic [pfta_pkg::COUNT_BITS-1:0]      used_pages,
    output logic [pfta_pkg::COUNT_BITS-1:0]      total_pages
);

    localparam int IW  = (TABLE_DEPTH > 2) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW  = $clog2(TABLE_DEPTH + 1);
    localparam int XW  = ((CW > pfta_pkg::COUNT_BITS) ? CW : pfta_pkg::COUNT_BITS) + 1;
    localparam int W   = ((pfta_pkg::REGION_BITS > FRAME_BITS) ?
                          pfta_pkg::REGION_BITS : FRAME_BITS) + 1;
    localparam int W2  = (W > XW) ? W : XW;

    typedef enum logic [2:0] {
        IDLE,
        ADD_CLAMP,
        ADD_FIT,
        ADD_PASS,
        ALLOC_SCAN,
        ALLOC_MARK,
        FREE_PASS
    } state_t;

    state_t state_reg, state_next;

    logic [IW-1:0]         pos_reg, pos_next;
    logic [CW-1:0]         ec_reg, ec_next;
    logic [CW-1:0]         used_reg, used_next;
    logic [pfta_pkg::COUNT_BITS-1:0] cnt_reg, cnt_next;
    logic [FRAME_BITS-1:0] base_reg, base_next;
    logic [W-1:0]          n_reg, n_next;
    logic [XW-1:0]         end_reg, end_next;
    logic [IW-1:0]         start_reg, start_next;
    logic [FRAME_BITS-1:0] first_reg, first_next;
    logic [FRAME_BITS-1:0] prev_reg, prev_next;
    logic [pfta_pkg::COUNT_BITS-1:0] run_reg, run_next;
    logic                  found_reg, found_next;
    logic [pfta_pkg::STATUS_BITS-1:0] st_reg, st_next;
    logic                  done_reg, done_next;
    logic [pfta_pkg::STATUS_BITS-1:0] status_reg, status_next;
    logic [pfta_pkg::OUT_FRAME_BITS-1:0] rf_reg, rf_next;

    logic [FRAME_BITS-1:0] cell_frame [TABLE_DEPTH];
    logic                  cell_free  [TABLE_DEPTH];
    logic [FRAME_BITS-1:0] w_frame;
    logic                  w_free;
    logic                  shift;

    logic [FRAME_BITS-1:0] in_frame;
    logic [XW-1:0]         pos_x, ec_x, cnt_x;
    logic                  last_pos;
    logic [W-1:0]          room;
    logic [W2-1:0]         room_t;
    logic                  hit;
    logic [XW-1:0]         sum_x;

    genvar g;
    generate
        for (g = 0; g < TABLE_DEPTH; g++)
        begin : g_ring
            if (g == TABLE_DEPTH - 1)
            begin : g_tail
                pfta_cell #(.FRAME_BITS(FRAME_BITS)) u_cell (
                    .clk       (clk),
                    .shift     (shift),
                    .frame_in  (w_frame),
                    .free_in   (w_free),
                    .frame_out (cell_frame[g]),
                    .free_out  (cell_free[g])
                );
            end
            else
            begin : g_body
                pfta_cell #(.FRAME_BITS(FRAME_BITS)) u_cell (
                    .clk       (clk),
                    .shift     (shift),
                    .frame_in  (cell_frame[g+1]),
                    .free_in   (cell_free[g+1]),
                    .frame_out (cell_frame[g]),
                    .free_out  (cell_free[g])
                );
            end
        end
    endgenerate

    assign in_frame = FRAME_BITS'(frame);
    assign pos_x    = XW'(pos_reg);
    assign ec_x     = XW'(ec_reg);
    assign cnt_x    = XW'(cnt_reg);
    assign last_pos = (pos_reg == IW'(TABLE_DEPTH - 1));
    assign shift    = (state_reg == ADD_PASS) || (state_reg == ALLOC_SCAN) ||
                      (state_reg == ALLOC_MARK) || (state_reg == FREE_PASS);

    always_comb
    begin
        state_next  = state_reg;
        pos_next    = pos_reg;
        ec_next     = ec_reg;
        used_next   = used_reg;
        cnt_next    = cnt_reg;
        base_next   = base_reg;
        n_next      = n_reg;
        end_next    = end_reg;
        start_next  = start_reg;
        first_next  = first_reg;
        prev_next   = prev_reg;
        run_next    = run_reg;
        found_next  = found_reg;
        st_next     = st_reg;
        done_next   = 1'b0;
        status_next = status_reg;
        rf_next     = rf_reg;
        w_frame     = cell_frame[0];
        w_free      = cell_free[0];
        room        = (W'(1) << FRAME_BITS) - W'(base_reg);
        room_t      = W2'(TABLE_DEPTH) - W2'(ec_reg);
        hit         = 1'b0;
        sum_x       = XW'(used_reg) + cnt_x;

        if (shift)
        begin
            pos_next = last_pos ? '0 : pos_reg + IW'(1);
        end

        unique case (state_reg)
            IDLE:
            begin
                if (start)
                begin
                    cnt_next   = page_count;
                    found_next = 1'b0;
                    run_next   = '0;
                    rf_next    = '0;
                    unique case (operation)
                        pfta_pkg::OP_ADD:
                        begin
                            base_next  = in_frame;
                            n_next     = W'(region_pages);
                            state_next = ADD_CLAMP;
                            if (in_frame == '0)
                            begin
                                if (region_pages == '0)
                                begin
                                    state_next  = IDLE;
                                    done_next   = 1'b1;
                                    status_next = pfta_pkg::ST_OK;
                                end
                                else
                                begin
                                    base_next = FRAME_BITS'(1);
                                    n_next    = W'(region_pages) - W'(1);
                                end
                            end
                        end
                        pfta_pkg::OP_ALLOC:
                        begin
                            if (page_count == '0)
                            begin
                                done_next   = 1'b1;
                                status_next = pfta_pkg::ST_NO_RUN;
                            end
                            else
                            begin
                                state_next = ALLOC_SCAN;
                            end
                        end
                        pfta_pkg::OP_FREE:
                        begin
                            base_next  = in_frame;
                            state_next = FREE_PASS;
                        end
                        default:
                        begin
                            done_next   = 1'b1;
                            status_next = pfta_pkg::ST_OK;
                        end
                    endcase
                end
            end
            ADD_CLAMP:
            begin
                if (n_reg > room)
                begin
                    n_next = room;
                end
                state_next = ADD_FIT;
            end
            ADD_FIT:
            begin
                if (W2'(n_reg) > room_t)
                begin
                    end_next = XW'(TABLE_DEPTH);
                    st_next  = pfta_pkg::ST_FULL;
                end
                else
                begin
                    end_next = XW'(W2'(ec_reg) + W2'(n_reg));
                    st_next  = pfta_pkg::ST_OK;
                end
                state_next = ADD_PASS;
            end
            ADD_PASS:
            begin
                if (pos_x >= ec_x && pos_x < end_reg)
                begin
                    w_frame   = base_reg;
                    w_free    = 1'b1;
                    base_next = base_reg + FRAME_BITS'(1);
                end
                if (last_pos)
                begin
                    ec_next     = CW'(end_reg);
                    state_next  = IDLE;
                    done_next   = 1'b1;
                    status_next = st_reg;
                end
            end
            ALLOC_SCAN:
            begin
                if (!found_reg && pos_x < ec_x)
                begin
                    prev_next = cell_frame[0];
                    if (cell_free[0] && run_reg != '0 &&
                        {1'b0, cell_frame[0]} == {1'b0, prev_reg} + (FRAME_BITS+1)'(1))
                    begin
                        run_next = run_reg + pfta_pkg::COUNT_BITS'(1);
                    end
                    else if (cell_free[0])
                    begin
                        run_next   = pfta_pkg::COUNT_BITS'(1);
                        first_next = cell_frame[0];
                        start_next = pos_reg;
                    end
                    else
                    begin
                        run_next = '0;
                    end
                    if (cell_free[0] && run_next == cnt_reg)
                    begin
                        found_next = 1'b1;
                    end
                end
                if (last_pos)
                begin
                    end_next = XW'(start_next) + cnt_x;
                    if (found_next)
                    begin
                        state_next = ALLOC_MARK;
                    end
                    else
                    begin
                        state_next  = IDLE;
                        done_next   = 1'b1;
                        status_next = pfta_pkg::ST_NO_RUN;
                    end
                end
            end
            ALLOC_MARK:
            begin
                if (pos_x >= XW'(start_reg) && pos_x < end_reg)
                begin
                    w_free = 1'b0;
                end
                if (last_pos)
                begin
                    used_next   = (sum_x > ec_x) ? ec_reg : CW'(sum_x);
                    state_next  = IDLE;
                    done_next   = 1'b1;
                    status_next = pfta_pkg::ST_OK;
                    rf_next     = pfta_pkg::OUT_FRAME_BITS'(first_reg);
                end
            end
            FREE_PASS:
            begin
                hit = !found_reg && pos_x < ec_x && (pos_x + cnt_x) <= ec_x &&
                      cell_frame[0] == base_reg;
                if (hit)
                begin
                    found_next = 1'b1;
                    end_next   = pos_x + cnt_x;
                end
                if ((hit && cnt_reg != '0) || (found_reg && pos_x < end_reg))
                begin
                    w_free = 1'b1;
                end
                if (last_pos)
                begin
                    state_next = IDLE;
                    done_next  = 1'b1;
                    if (found_next)
                    begin
                        used_next   = (XW'(used_reg) > cnt_x) ?
                                      CW'(XW'(used_reg) - cnt_x) : '0;
                        status_next = pfta_pkg::ST_OK;
                    end
                    else
                    begin
                        status_next = pfta_pkg::ST_NOT_FOUND;
                    end
                end
            end
            default:
            begin
                state_next = IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= IDLE;
            pos_reg    <= '0;
            ec_reg     <= '0;
            used_reg   <= '0;
            found_reg  <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            pos_reg    <= pos_next;
            ec_reg     <= ec_next;
            used_reg   <= used_next;
            found_reg  <= found_next;
            done_reg   <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg    <= cnt_next;
        base_reg   <= base_next;
        n_reg      <= n_next;
        end_reg    <= end_next;
        start_reg  <= start_next;
        first_reg  <= first_next;
        prev_reg   <= prev_next;
        run_reg    <= run_next;
        st_reg     <= st_next;
        status_reg <= status_next;
        rf_reg     <= rf_next;
    end

    assign busy         = (state_reg != IDLE);
    assign done         = done_reg;
    assign status       = status_reg;
    assign result_frame = rf_reg;
    assign used_pages   = pfta_pkg::COUNT_BITS'(used_reg);
    assign total_pages  = pfta_pkg::COUNT_BITS'(ec_reg);

`ifndef SYNTHESIS
    a_used_le_total: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= ec_reg)
        else $error("used count above entry count");

    a_ring_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        !busy |-> pos_reg == '0)
        else $error("ring not aligned while idle");

    a_done_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy && ($past(busy) || $past(start)))
        else $error("result without request");

    a_frame_only_alloc: assert property (@(posedge clk) disable iff (!rst_n)
        done && status != pfta_pkg::ST_OK |-> result_frame == '0)
        else $error("frame reported on failure");
`endif

endmodule

// ----- design/pfta_cell.sv -----
module pfta_cell #(
    parameter int FRAME_BITS = 40
) (
    input  logic                  clk,
    input  logic                  shift,
    input  logic [FRAME_BITS-1:0] frame_in,
    input  logic                  free_in,
    output logic [FRAME_BITS-1:0] frame_out,
    output logic                  free_out
);

    logic [FRAME_BITS-1:0] frame_reg;
    logic                  free_reg;

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            frame_reg <= frame_in;
            free_reg  <= free_in;
        end
    end

    assign frame_out = frame_reg;
    assign free_out  = free_reg;

endmodule
